@@ hw/rtl/bbse_pkg.sv @@
// package for the bicubic bezier surface evaluator
// types, constants and the lerp control struct used by the evaluator and lerp unit
`timescale 1ns / 1ps

package bbse_pkg;

  localparam int unsigned MaxPatchesU     = 8;
  localparam int unsigned MaxPatchesV     = 8;
  localparam int unsigned PointStoreDepth = 1024;
  localparam int unsigned OneQ16          = 65536;

  localparam logic [1:0] CfgPatchesU  = 2'd0;
  localparam logic [1:0] CfgPatchesV  = 2'd1;
  localparam logic [1:0] CfgCylinder  = 2'd2;

  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdSample = 1'b1;

  typedef struct packed {
    logic        command;
    logic [9:0]  point_index;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [16:0] sample_u;
    logic [16:0] sample_v;
  } req_t;

  typedef struct packed {
    logic [31:0] surface_x;
    logic [31:0] surface_y;
    logic [31:0] surface_z;
  } res_t;

  typedef enum logic [2:0] {
    StIdle,
    StSplit,
    StFetch,
    StLerp,
    StDone
  } state_e;

  // lerp unit control
  typedef struct packed {
    logic        go;
    logic [16:0] t;
  } lerp_ctl_t;

endpackage

@@ hw/rtl/bicubic_bezier_surface_eval.sv @@
// bicubic bezier surface evaluator, top level with point store and sequencer
// depends on bbse_pkg and bbse_lerp
`timescale 1ns / 1ps

// A write request stores one control point in the point store. A sample request
// runs through the split state, 16 point fetches from the point store, 90 scalar
// lerps (five cubics of six lerps for each of x, y and z) through one shared
// two-stage lerp unit, each lerp issued after the last result is back, and the
// done state. busy is high from the split state through the done state; done_o is
// high for one cycle in the first cycle that busy is low, with the result on
// result_o, and cannot be stalled, and a new request may be accepted in that same
// cycle.
module bicubic_bezier_surface_eval #(
  parameter int unsigned MAX_PATCHES_U     = bbse_pkg::MaxPatchesU,
  parameter int unsigned MAX_PATCHES_V     = bbse_pkg::MaxPatchesV
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  bbse_pkg::req_t   req_i,
  output logic             done_o,
  output bbse_pkg::res_t   result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [3:0]       cfg_data_i
);

  localparam int unsigned AW = $clog2(bbse_pkg::PointStoreDepth);

  logic [3:0] pu_q, pv_q;
  logic       cyl_q;
  logic [4:0] nu, nv;

  bbse_pkg::state_e st_q, st_d;

  logic [95:0] mem [bbse_pkg::PointStoreDepth];
  logic [95:0] rd_q;
  logic [AW-1:0] raddr;

  logic [16:0] u_q, v_q, lu_q, lv_q;
  logic [4:0]  pi_q, pj_q;
  logic [3:0]  fcnt_q;
  logic        rvld_q;
  logic [3:0]  rslot_q;
  logic signed [31:0] pts_q [16][3];
  logic signed [31:0] col_q [4][3];
  // lerp schedule: coord, column (4 = v pass), level pair index
  logic [1:0] lc_q;
  logic [2:0] lcol_q;
  logic [2:0] lk_q;
  logic       lwait_q;
  logic [1:0] nc;
  logic [2:0] ncol;
  logic signed [31:0] w_q [4];
  logic signed [31:0] la, lb, ly;
  logic               lvalid;
  bbse_pkg::lerp_ctl_t lctl;
  bbse_pkg::res_t res_q;
  logic done_q;

  logic accept;
  assign accept = start && !busy;

  always_comb begin
    nu = (pu_q == 4'd0) ? 5'd1 : (32'(pu_q) > MAX_PATCHES_U) ? 5'(MAX_PATCHES_U)
         : {1'b0, pu_q};
    nv = (pv_q == 4'd0) ? 5'd1 : (32'(pv_q) > MAX_PATCHES_V) ? 5'(MAX_PATCHES_V)
         : {1'b0, pv_q};
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pu_q  <= 4'd1;
      pv_q  <= 4'd1;
      cyl_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bbse_pkg::CfgPatchesU: pu_q  <= cfg_data_i;
        bbse_pkg::CfgPatchesV: pv_q  <= cfg_data_i;
        bbse_pkg::CfgCylinder: cyl_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // address of point fcnt (ii low bits, jj high bits)
  logic [15:0] row, addr_w;
  logic [1:0]  ii, jj;
  logic [7:0]  cidx;
  always_comb begin
    ii   = fcnt_q[1:0];
    jj   = fcnt_q[3:2];
    cidx = 8'd0;
    if (!cyl_q) begin
      row    = 16'(3 * nu + 1);
      addr_w = 16'(3 * (row * pj_q + pi_q) + row * jj + ii);
    end else begin
      row    = 16'(3 * nu);
      cidx   = 8'(3 * pi_q + ii);
      if (cidx >= row[7:0]) cidx = cidx - row[7:0];
      addr_w = 16'(3 * (row * pj_q) + row * jj + cidx);
    end
    raddr = addr_w[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.command == bbse_pkg::CmdWrite)
      mem[req_i.point_index[AW-1:0]] <= {req_i.point_x, req_i.point_y, req_i.point_z};
    rd_q <= mem[raddr];
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      bbse_pkg::StIdle:  if (accept && req_i.command == bbse_pkg::CmdSample)
                           st_d = bbse_pkg::StSplit;
      bbse_pkg::StSplit: st_d = bbse_pkg::StFetch;
      bbse_pkg::StFetch: if (fcnt_q == 4'd15) st_d = bbse_pkg::StLerp;
      bbse_pkg::StLerp:  if (lvalid && lcol_q == 3'd4 && lk_q == 3'd5 && lc_q == 2'd2)
                           st_d = bbse_pkg::StDone;
      bbse_pkg::StDone:  st_d = bbse_pkg::StIdle;
      default:           st_d = bbse_pkg::StIdle;
    endcase
  end

  assign busy = (st_q != bbse_pkg::StIdle);

  // level operands from working row
  always_comb begin
    unique case (lk_q)
      3'd0: begin la = w_q[0]; lb = w_q[1]; end
      3'd1: begin la = w_q[1]; lb = w_q[2]; end
      3'd2: begin la = w_q[2]; lb = w_q[3]; end
      3'd3: begin la = w_q[0]; lb = w_q[1]; end
      3'd4: begin la = w_q[1]; lb = w_q[2]; end
      default: begin la = w_q[0]; lb = w_q[1]; end
    endcase
    lctl.go = (st_q == bbse_pkg::StLerp) && !lwait_q;
    lctl.t  = (lcol_q == 3'd4) ? lv_q : lu_q;
  end

  // coord and column of the next cubic
  always_comb begin
    nc   = lc_q + 2'd1;
    ncol = lcol_q;
    if (st_q == bbse_pkg::StFetch) begin
      nc   = '0;
      ncol = '0;
    end else if (lc_q == 2'd2) begin
      nc   = '0;
      ncol = lcol_q + 3'd1;
    end
  end

  bbse_lerp u_lerp (
    .clk_i, .rst_ni, .ctl_i(lctl), .a_i(la), .b_i(lb), .y_o(ly), .valid_o(lvalid)
  );

  logic [16:0] uc, vc;
  logic [21:0] su, sv;
  always_comb begin
    uc = u_q;
    if (u_q > 17'(bbse_pkg::OneQ16)) uc = cyl_q ? {1'b0, u_q[15:0]} : 17'(bbse_pkg::OneQ16);
    vc = (v_q > 17'(bbse_pkg::OneQ16)) ? 17'(bbse_pkg::OneQ16) : v_q;
    su = 22'(uc) * 22'(nu);
    sv = 22'(vc) * 22'(nv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= bbse_pkg::StIdle;
      fcnt_q  <= '0;
      rvld_q  <= 1'b0;
      lwait_q <= 1'b0;
      lc_q    <= '0;
      lcol_q  <= '0;
      lk_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == bbse_pkg::StDone);
      rvld_q <= (st_q == bbse_pkg::StFetch);
      if (st_q == bbse_pkg::StFetch) fcnt_q <= fcnt_q + 4'd1;
      if (st_q == bbse_pkg::StSplit) begin
        fcnt_q <= '0;
        lc_q   <= '0;
        lcol_q <= '0;
        lk_q   <= '0;
      end
      if (lctl.go) lwait_q <= 1'b1;
      if (lvalid) begin
        lwait_q <= 1'b0;
        if (lk_q == 3'd5) begin
          lk_q <= '0;
          if (lc_q == 2'd2) begin
            lc_q   <= '0;
            lcol_q <= lcol_q + 3'd1;
          end else begin
            lc_q <= lc_q + 2'd1;
          end
        end else begin
          lk_q <= lk_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      u_q <= req_i.sample_u;
      v_q <= req_i.sample_v;
    end
    if (st_q == bbse_pkg::StSplit) begin
      if (uc >= 17'(bbse_pkg::OneQ16)) begin
        pi_q <= nu - 5'd1; lu_q <= 17'(bbse_pkg::OneQ16);
      end else begin
        pi_q <= su[20:16]; lu_q <= {1'b0, su[15:0]};
      end
      if (vc >= 17'(bbse_pkg::OneQ16)) begin
        pj_q <= nv - 5'd1; lv_q <= 17'(bbse_pkg::OneQ16);
      end else begin
        pj_q <= sv[20:16]; lv_q <= {1'b0, sv[15:0]};
      end
    end
    rslot_q <= fcnt_q;
    if (rvld_q) begin
      pts_q[rslot_q][0] <= rd_q[95:64];
      pts_q[rslot_q][1] <= rd_q[63:32];
      pts_q[rslot_q][2] <= rd_q[31:0];
    end
    // load working row before the first lerp of each cubic
    if ((st_q == bbse_pkg::StFetch && fcnt_q == 4'd15) ||
        (lvalid && lk_q == 3'd5 && !(lcol_q == 3'd4 && lc_q == 2'd2))) begin
      for (int k = 0; k < 4; k++)
        w_q[k] <= (ncol == 3'd4) ? col_q[k][nc] : pts_q[{ncol[1:0], 2'(k)}][nc];
    end
    if (lvalid) begin
      unique case (lk_q)
        3'd0: w_q[0] <= ly;
        3'd1: w_q[1] <= ly;
        3'd2: w_q[2] <= ly;
        3'd3: w_q[0] <= ly;
        3'd4: w_q[1] <= ly;
        default: begin
          if (lcol_q == 3'd4) begin
            unique case (lc_q)
              2'd0: res_q.surface_x <= ly;
              2'd1: res_q.surface_y <= ly;
              default: res_q.surface_z <= ly;
            endcase
          end else begin
            col_q[lcol_q[1:0]][lc_q] <= ly;
          end
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ hw/rtl/bbse_lerp.sv @@
// shared lerp unit, two stage: product then rounding and floor shift
// depends on bbse_pkg
`timescale 1ns / 1ps

module bbse_lerp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bbse_pkg::lerp_ctl_t  ctl_i,
  input  logic signed [31:0]   a_i,
  input  logic signed [31:0]   b_i,
  output logic signed [31:0]   y_o,
  output logic                 valid_o
);

  logic signed [49:0] pa_q, pb_q;
  logic               v1_q, v2_q;
  logic signed [31:0] y_q;
  logic signed [50:0] sum;
  logic signed [49:0] a_x, b_x, t_x, omt_x;

  assign a_x   = 50'(a_i);
  assign b_x   = 50'(b_i);
  assign t_x   = 50'({1'b0, ctl_i.t});
  assign omt_x = 50'(18'(bbse_pkg::OneQ16) - {1'b0, ctl_i.t});

  assign sum = 51'(pa_q) + 51'(pb_q) + 51'sd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.go;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= a_x * omt_x;
    pb_q <= b_x * t_x;
    y_q  <= sum[47:16];
  end

  assign y_o     = y_q;
  assign valid_o = v2_q;

endmodule

@@ hw/rtl/bbse_checker.sv @@
// port level checks for the surface evaluator
// depends on bicubic_bezier_surface_eval ports, bound below
`timescale 1ns / 1ps

module bbse_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic cfg_ready_o
);

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without request in progress");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_idle_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy while result shown");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o) else $error("config port not ready");

endmodule

bind bicubic_bezier_surface_eval bbse_checker u_bbse_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .cfg_ready_o
);
